@@ sv/qsu_pkg.sv @@
`default_nettype none
package qsu_pkg;

  // decoder modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_STR  = 3'd1;
  localparam logic [2:0] MODE_ESC  = 3'd2;
  localparam logic [2:0] MODE_HEX1 = 3'd3;
  localparam logic [2:0] MODE_BS   = 3'd4;
  localparam logic [2:0] MODE_U    = 3'd5;
  localparam logic [2:0] MODE_HEX2 = 3'd6;

  // result status codes
  localparam logic [3:0] ST_BYTE   = 4'd0;
  localparam logic [3:0] ST_DONE   = 4'd1;
  localparam logic [3:0] ST_CTRL   = 4'd2;
  localparam logic [3:0] ST_TESC   = 4'd3;
  localparam logic [3:0] ST_BESC   = 4'd4;
  localparam logic [3:0] ST_BHEX   = 4'd5;
  localparam logic [3:0] ST_TU     = 4'd6;
  localparam logic [3:0] ST_NOLOW  = 4'd7;
  localparam logic [3:0] ST_BLOW   = 4'd8;
  localparam logic [3:0] ST_BCP    = 4'd9;
  localparam logic [3:0] ST_UNTERM = 4'd10;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One decoded step: up to four words sharing one status.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
    logic [3:0]      status;
  } res_t;

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

  // single-character escapes: {ok, byte}
  function automatic logic [8:0] esc_map(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      CH_QUOTE, CH_BSL, CH_SLASH: r = {1'b1, b};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic res_t utf8_enc(input logic [20:0] cp);
    res_t r;
    r = '0;
    r.status = ST_BYTE;
    if (cp <= 21'h7f) begin
      r.bytes[0] = cp[7:0];
      r.cnt_m1   = 2'd0;
    end else if (cp <= 21'h7ff) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt_m1   = 2'd1;
    end else if (cp <= 21'hffff) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt_m1   = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt_m1   = 2'd3;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/qsu_decode.sv @@
`default_nettype none
module qsu_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic [7:0]    text_byte_i,
  input  wire logic          begin_i,
  input  wire logic          end_i,
  output logic               push_o,
  output qsu_pkg::res_t      res_o
);

  logic [2:0]  mode_q, mode_d;
  logic [1:0]  nd_q, nd_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] hi_q, hi_d;

  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [15:0] acc_sh;
  logic [20:0] cp_pair;
  logic        has_err, emit, idle;
  logic [3:0]  err;
  qsu_pkg::res_t res;

  assign hex     = qsu_pkg::hex_val(text_byte_i);
  assign esc     = qsu_pkg::esc_map(text_byte_i);
  assign acc_sh  = {acc_q[11:0], hex[3:0]};
  // hi and lo surrogate payloads are the low ten bits of each quad
  assign cp_pair = {1'b0, hi_q[9:0], acc_sh[9:0]} + 21'h10000;

  always_comb begin
    mode_d  = mode_q;
    nd_d    = nd_q;
    acc_d   = acc_q;
    hi_d    = hi_q;
    has_err = 1'b0;
    err     = qsu_pkg::ST_BYTE;
    emit    = 1'b0;
    idle    = 1'b0;
    res     = '0;
    if (begin_i) begin
      mode_d = qsu_pkg::MODE_STR;
      nd_d   = 2'd0;
      acc_d  = 16'd0;
      hi_d   = 16'd0;
    end else begin
      case (mode_q)
        qsu_pkg::MODE_STR: begin
          if (text_byte_i == qsu_pkg::CH_QUOTE) begin
            has_err = 1'b1; err = qsu_pkg::ST_DONE;
          end else if (text_byte_i < qsu_pkg::CH_SPACE) begin
            has_err = 1'b1; err = qsu_pkg::ST_CTRL;
          end else if (text_byte_i == qsu_pkg::CH_BSL) begin
            if (end_i) begin
              has_err = 1'b1; err = qsu_pkg::ST_TESC;
            end else begin
              mode_d = qsu_pkg::MODE_ESC;
            end
          end else begin
            emit = 1'b1;
            res.bytes[0] = text_byte_i;
          end
        end
        qsu_pkg::MODE_ESC: begin
          if (esc[8]) begin
            emit = 1'b1;
            res.bytes[0] = esc[7:0];
            mode_d = qsu_pkg::MODE_STR;
          end else if (text_byte_i == qsu_pkg::CH_U) begin
            if (end_i) begin
              has_err = 1'b1; err = qsu_pkg::ST_TU;
            end else begin
              mode_d = qsu_pkg::MODE_HEX1;
              nd_d   = 2'd0;
              acc_d  = 16'd0;
            end
          end else begin
            has_err = 1'b1; err = qsu_pkg::ST_BESC;
          end
        end
        qsu_pkg::MODE_HEX1, qsu_pkg::MODE_HEX2: begin
          if (!hex[4]) begin
            has_err = 1'b1; err = qsu_pkg::ST_BHEX;
          end else begin
            acc_d = acc_sh;
            if (nd_q != 2'd3) begin
              nd_d = nd_q + 2'd1;
              if (end_i) begin
                has_err = 1'b1; err = qsu_pkg::ST_TU;
              end
            end else begin
              nd_d = 2'd0;
              if (mode_q == qsu_pkg::MODE_HEX1) begin
                if (acc_sh inside {[16'hd800:16'hdbff]}) begin
                  hi_d = acc_sh;
                  if (end_i) begin
                    has_err = 1'b1; err = qsu_pkg::ST_NOLOW;
                  end else begin
                    mode_d = qsu_pkg::MODE_BS;
                  end
                end else if (acc_sh inside {[16'hdc00:16'hdfff]}) begin
                  has_err = 1'b1; err = qsu_pkg::ST_BCP;
                end else begin
                  emit   = 1'b1;
                  res    = qsu_pkg::utf8_enc({5'd0, acc_sh});
                  mode_d = qsu_pkg::MODE_STR;
                end
              end else begin
                if (!(acc_sh inside {[16'hdc00:16'hdfff]})) begin
                  has_err = 1'b1; err = qsu_pkg::ST_BLOW;
                end else begin
                  emit   = 1'b1;
                  res    = qsu_pkg::utf8_enc(cp_pair);
                  mode_d = qsu_pkg::MODE_STR;
                end
              end
            end
          end
        end
        qsu_pkg::MODE_BS: begin
          if (text_byte_i != qsu_pkg::CH_BSL || end_i) begin
            has_err = 1'b1; err = qsu_pkg::ST_NOLOW;
          end else begin
            mode_d = qsu_pkg::MODE_U;
          end
        end
        qsu_pkg::MODE_U: begin
          if (text_byte_i != qsu_pkg::CH_U) begin
            has_err = 1'b1; err = qsu_pkg::ST_NOLOW;
          end else if (end_i) begin
            has_err = 1'b1; err = qsu_pkg::ST_TU;
          end else begin
            mode_d = qsu_pkg::MODE_HEX2;
            nd_d   = 2'd0;
            acc_d  = 16'd0;
          end
        end
        default: begin
          mode_d = qsu_pkg::MODE_IDLE;
          idle   = 1'b1;
        end
      endcase
    end

    // text ran out mid-string: drop any decoded words
    if (!idle && !has_err && end_i) begin
      has_err = 1'b1;
      err     = qsu_pkg::ST_UNTERM;
    end
    if (has_err) begin
      res        = '0;
      res.status = err;
      mode_d     = qsu_pkg::MODE_IDLE;
      nd_d       = 2'd0;
      acc_d      = 16'd0;
    end
  end

  assign push_o = adv_i && (has_err || emit);
  assign res_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qsu_pkg::MODE_IDLE;
      nd_q   <= 2'd0;
      acc_q  <= 16'd0;
      hi_q   <= 16'd0;
    end else if (adv_i) begin
      mode_q <= mode_d;
      nd_q   <= nd_d;
      acc_q  <= acc_d;
      hi_q   <= hi_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/qsu_out_queue.sv @@
`default_nettype none
module qsu_out_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire qsu_pkg::res_t res_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic [3:0]         status_o,
  output logic               last_of_run_o
);

  qsu_pkg::res_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic [1:0]    idx_q;
  qsu_pkg::res_t head;
  logic          take, pop;

  assign head          = mem_q[rd_ptr_q];
  assign full_o        = (cnt_q == 2'd2);
  assign out_valid_o   = (cnt_q != 2'd0);
  assign out_byte_o    = head.bytes[idx_q];
  assign status_o      = head.status;
  assign last_of_run_o = (idx_q == head.cnt_m1);
  assign take          = out_valid_o && !out_stall_i;
  assign pop           = take && last_of_run_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
        idx_q    <= 2'd0;
      end else if (take) begin
        idx_q <= idx_q + 2'd1;
      end
      if (push_i && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ sv/quoted_string_unescape_utf8.sv @@
// Quoted string unescaper: turns the text of one JSON-style quoted value
// into UTF-8 words.
// Input channel: one text word per accepted cycle with begin_string_i on
// the opening quote and end_of_text_i on the final word of the text.
// Output channel: out_byte_o with status_o (0 = data word, 1 = done,
// 2..10 = error code); last_of_run_o marks the final output word caused
// by one input word. An input word gives zero to four output words.
// Path: an accepted input word passes through the input register, then is
// decoded into the result queue, from which its first output is offered.
// Throughput: one input word per cycle while in_stall_o is low; output
// drains one word per cycle unless out_stall_i is set, so a \u escape
// yielding up to four words keeps up, as the escape spans six or more inputs.
// Reset: decoder returns to idle (waiting for a begin_string_i word) and the
// result queue empties; no outputs are pending.
// Stall: out_stall_i holds the current output word; the two-entry result
// queue and input register then fill and in_stall_o rises. in_stall_o
// comes straight from registers.
`default_nettype none
module quoted_string_unescape_utf8 (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       begin_string_i,
  input  wire logic       end_of_text_i,
  // output channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [3:0]      status_o,
  output logic            last_of_run_o
);

  // input register
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_begin_q;
  logic       a_end_q;

  logic          q_full;
  logic          adv;
  logic          accept;
  logic          push;
  qsu_pkg::res_t res;

  // Stage A advances into the decoder whenever the queue has room; the
  // decoder state only moves on an advance.
  assign adv        = a_valid_q && !q_full;
  assign in_stall_o = a_valid_q && q_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_byte_q  <= text_byte_i;
      a_begin_q <= begin_string_i;
      a_end_q   <= end_of_text_i;
    end
  end

  qsu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .text_byte_i (a_byte_q),
    .begin_i     (a_begin_q),
    .end_i       (a_end_q),
    .push_o      (push),
    .res_o       (res)
  );

  qsu_out_queue u_out_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .res_i         (res),
    .full_o        (q_full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 100;   // long receiver hold-off, fills the block
  localparam int STUCK_LIMIT  = 1000;  // cycles without any handshake before giving up
  localparam int TAIL_CYCLES  = 6;     // extra wait once no owed words remain
  localparam int PHASE_ITEMS  = 90;    // random text words per idle/stall phase

  // one output word as seen on the result channel
  typedef struct packed {
    logic [7:0] ob;
    logic [3:0] st;
    logic       last;
  } word_t;

  // one input word as driven on the text channel
  typedef struct packed {
    logic [7:0] txt;
    logic       first;
    logic       eot;
  } in_word_t;

  // Shadow decoder plus queue of output words still owed by the block.
  class unescape_scoreboard;
    word_t       pending[$];
    word_t       step_out[$];
    int          errors;
    int          words_in;
    int          words_out;
    logic [15:0] seen_status;
    // decoder state
    logic [2:0]  mode;
    logic [1:0]  ndig;
    logic [15:0] acc;
    logic [15:0] high_sur;

    function new();
      errors      = 0;
      words_in    = 0;
      words_out   = 0;
      seen_status = '0;
      mode        = qsu_pkg::MODE_IDLE;
      ndig        = '0;
      acc         = '0;
      high_sur    = '0;
    endfunction

    local function int nibble_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
    endfunction

    local function void emit(logic [7:0] v);
      step_out.insert(step_out.size(), word_t'{ob: v, st: qsu_pkg::ST_BYTE, last: 1'b0});
    endfunction

    local function void emit_cp(logic [20:0] cp);
      if (cp <= 21'h7f) begin
        emit(cp[7:0]);
      end else if (cp <= 21'h7ff) begin
        emit({3'b110, cp[10:6]});
        emit({2'b10, cp[5:0]});
      end else if (cp <= 21'hffff) begin
        emit({4'b1110, cp[15:12]});
        emit({2'b10, cp[11:6]});
        emit({2'b10, cp[5:0]});
      end else begin
        emit({5'b11110, cp[20:18]});
        emit({2'b10, cp[17:12]});
        emit({2'b10, cp[11:6]});
        emit({2'b10, cp[5:0]});
      end
    endfunction

    // Accepted text word: advance the shadow decoder, queue what it owes.
    function void note_word(logic [7:0] b, logic first, logic eot);
      logic [3:0] err;  // stays ST_BYTE while the step decodes cleanly
      int         d;
      word_t      w;
      words_in++;
      step_out.delete();
      err = qsu_pkg::ST_BYTE;
      if (first) begin
        mode     = qsu_pkg::MODE_STR;
        ndig     = '0;
        acc      = '0;
        high_sur = '0;
      end else begin
        case (mode)
          qsu_pkg::MODE_STR: begin
            if (b == qsu_pkg::CH_QUOTE) err = qsu_pkg::ST_DONE;
            else if (b < qsu_pkg::CH_SPACE) err = qsu_pkg::ST_CTRL;
            else if (b == qsu_pkg::CH_BSL) begin
              if (eot) err = qsu_pkg::ST_TESC;
              else mode = qsu_pkg::MODE_ESC;
            end else emit(b);
          end
          qsu_pkg::MODE_ESC: begin
            case (b)
              qsu_pkg::CH_QUOTE, qsu_pkg::CH_BSL, qsu_pkg::CH_SLASH: begin
                emit(b);
                mode = qsu_pkg::MODE_STR;
              end
              "b": begin emit(8'h08); mode = qsu_pkg::MODE_STR; end
              "f": begin emit(8'h0c); mode = qsu_pkg::MODE_STR; end
              "n": begin emit(8'h0a); mode = qsu_pkg::MODE_STR; end
              "r": begin emit(8'h0d); mode = qsu_pkg::MODE_STR; end
              "t": begin emit(8'h09); mode = qsu_pkg::MODE_STR; end
              qsu_pkg::CH_U: begin
                if (eot) err = qsu_pkg::ST_TU;
                else begin
                  mode = qsu_pkg::MODE_HEX1;
                  ndig = '0;
                  acc  = '0;
                end
              end
              default: err = qsu_pkg::ST_BESC;
            endcase
          end
          qsu_pkg::MODE_HEX1, qsu_pkg::MODE_HEX2: begin
            d = nibble_of(b);
            if (d < 0) err = qsu_pkg::ST_BHEX;
            else begin
              acc = {acc[11:0], d[3:0]};
              if (ndig != 2'd3) begin
                ndig++;
                if (eot) err = qsu_pkg::ST_TU;
              end else begin
                ndig = '0;
                if (mode == qsu_pkg::MODE_HEX1) begin
                  if (acc >= 16'hd800 && acc <= 16'hdbff) begin
                    high_sur = acc;
                    if (eot) err = qsu_pkg::ST_NOLOW;
                    else mode = qsu_pkg::MODE_BS;
                  end else if (acc >= 16'hdc00 && acc <= 16'hdfff) begin
                    err = qsu_pkg::ST_BCP;   // low half with no high half before it
                  end else begin
                    emit_cp({5'd0, acc});
                    mode = qsu_pkg::MODE_STR;
                  end
                end else if (acc < 16'hdc00 || acc > 16'hdfff) begin
                  err = qsu_pkg::ST_BLOW;
                end else begin
                  emit_cp(21'h10000 + {1'b0, high_sur[9:0], acc[9:0]});
                  mode = qsu_pkg::MODE_STR;
                end
              end
            end
          end
          qsu_pkg::MODE_BS: begin
            if (b != qsu_pkg::CH_BSL || eot) err = qsu_pkg::ST_NOLOW;
            else mode = qsu_pkg::MODE_U;
          end
          qsu_pkg::MODE_U: begin
            if (b != qsu_pkg::CH_U) err = qsu_pkg::ST_NOLOW;
            else if (eot) err = qsu_pkg::ST_TU;
            else begin
              mode = qsu_pkg::MODE_HEX2;
              ndig = '0;
              acc  = '0;
            end
          end
          default: begin
            // idle: word is ignored, even with end of text
            mode = qsu_pkg::MODE_IDLE;
            return;
          end
        endcase
      end

      // text ran out mid-string: decoded bytes of this step are dropped
      if (err == qsu_pkg::ST_BYTE && eot) err = qsu_pkg::ST_UNTERM;
      if (err != qsu_pkg::ST_BYTE) begin
        step_out.delete();
        step_out.insert(0, word_t'{ob: 8'h00, st: err, last: 1'b0});
        mode = qsu_pkg::MODE_IDLE;
        ndig = '0;
        acc  = '0;
      end
      foreach (step_out[i]) begin
        w      = step_out[i];
        w.last = (i == step_out.size() - 1);
        pending.insert(pending.size(), w);
      end
    endfunction

    // Accepted output word: compare against the oldest owed word.
    function void check_result(logic [7:0] ob, logic [3:0] st, logic last);
      word_t want;
      if (pending.size() == 0) begin
        $error("unexpected output word: out_byte %h status %0d last_of_run %b", ob, st, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      words_out++;
      if (st <= qsu_pkg::ST_UNTERM) seen_status[st] = 1'b1;
      if (ob !== want.ob) begin
        $error("out_byte: expected %h, got %h", want.ob, ob);
        errors++;
      end
      if (st !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, st);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] text_byte_i;
  logic       begin_string_i;
  logic       end_of_text_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [3:0] status_o;
  logic       last_of_run_o;

  quoted_string_unescape_utf8 u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .begin_string_i (begin_string_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .last_of_run_o  (last_of_run_o)
  );

  unescape_scoreboard sb = new();

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall at stall_pct, plus a long hold-off on request.
  // A toggle of hold_tog asks for a solid stall counted down from HOLD_CYCLES;
  // the count is kept here so the sender never has to wait on it.
  // ---------------------------------------------------------------------------
  int   stall_pct = 0;
  logic hold_tog  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen   <= hold_tog;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitors: both channels sampled at the rising edge, pre-update values.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(out_byte_o, status_o, last_of_run_o);
      if (in_valid_i && !in_stall_o)
        sb.note_word(text_byte_i, begin_string_i, end_of_text_i);
    end
  end

  // Watchdog: any handshake on either side resets the count.
  int stuck = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  int       send_idle_pct = 0;
  int       items_sent    = 0;
  int       strings_sent  = 0;
  in_word_t text_q[$];

  // Offer one word; random idle cycles first, then hold until accepted.
  task automatic send_word(input logic [7:0] b, input logic first, input logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    text_byte_i    <= b;
    begin_string_i <= first;
    end_of_text_i  <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_text();
    foreach (text_q[i]) begin
      send_word(text_q[i].txt, text_q[i].first, text_q[i].eot);
      items_sent++;
    end
    text_q.delete();
    strings_sent++;
  endtask

  // Stop offering and let every owed word come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_word(logic [7:0] b, logic first, logic eot);
    text_q.insert(text_q.size(), in_word_t'{txt: b, first: first, eot: eot});
  endfunction

  function automatic void push_txt(logic [7:0] b);
    add_word(b, 1'b0, 1'b0);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 4'd10);
  endfunction

  // \uXXXX with mixed-case digits
  function automatic void push_u(logic [15:0] v);
    push_txt(qsu_pkg::CH_BSL);
    push_txt(qsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--) push_txt(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'($urandom_range(16'hd800, 16'hdbff));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'($urandom_range(16'hdc00, 16'hdfff));
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hff));
    while (b == qsu_pkg::CH_QUOTE || b == qsu_pkg::CH_BSL);
    return b;
  endfunction

  // Well-formed piece of string content.
  function automatic void add_token();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: push_txt(rand_plain());
      4: begin
        case ($urandom_range(0, 7))
          0: c = qsu_pkg::CH_QUOTE;
          1: c = qsu_pkg::CH_BSL;
          2: c = qsu_pkg::CH_SLASH;
          3: c = "b";
          4: c = "f";
          5: c = "n";
          6: c = "r";
          default: c = "t";
        endcase
        push_txt(qsu_pkg::CH_BSL);
        push_txt(c);
      end
      5: push_u(16'($urandom_range(0, 16'h7f)));
      6: push_u(16'($urandom_range(16'h80, 16'h7ff)));
      7: begin
        do v = 16'($urandom_range(16'h800, 16'hffff)); while (v >= 16'hd800 && v <= 16'hdfff);
        push_u(v);
      end
      8: begin
        push_u(rand_high());
        push_u(rand_low());
      end
      default: begin
        case ($urandom_range(0, 2))
          0: push_txt(qsu_pkg::CH_SPACE);
          1: push_txt(8'hff);
          default: push_txt(8'h7f);
        endcase
      end
    endcase
  endfunction

  // Malformed piece that should end the string with an error status.
  function automatic void add_fault();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(0, 6))
      0: push_txt(8'($urandom_range(0, 8'h1f)));
      1: begin
        do c = 8'($urandom_range(0, 255));
        while (c inside {qsu_pkg::CH_QUOTE, qsu_pkg::CH_BSL, qsu_pkg::CH_SLASH, qsu_pkg::CH_U,
                         "b", "f", "n", "r", "t"});
        push_txt(qsu_pkg::CH_BSL);
        push_txt(c);
      end
      2: begin
        push_txt(qsu_pkg::CH_BSL);
        push_txt(qsu_pkg::CH_U);
        repeat ($urandom_range(0, 3)) push_txt(hex_char(4'($urandom_range(0, 15))));
        do c = 8'($urandom_range(0, 255)); while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
        push_txt(c);
      end
      3: push_u(rand_low());
      4: begin
        push_u(rand_high());
        push_txt(rand_plain());
      end
      5: begin
        push_u(rand_high());
        push_txt(qsu_pkg::CH_BSL);
        do c = 8'($urandom_range(0, 255)); while (c == qsu_pkg::CH_U);
        push_txt(c);
      end
      default: begin
        push_u(rand_high());
        do v = 16'($urandom()); while (v >= 16'hdc00 && v <= 16'hdfff);
        push_u(v);
      end
    endcase
  endfunction

  // One random string: opening word, content, then one of several endings.
  task automatic random_string();
    int       ntok;
    int       ending;
    int       cut;
    in_word_t w;
    w.txt   = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : qsu_pkg::CH_QUOTE;
    w.first = 1'b1;
    w.eot   = ($urandom_range(0, 39) == 0);
    add_word(w.txt, w.first, w.eot);
    if (!w.eot) begin
      ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      repeat (ntok) add_token();
      ending = $urandom_range(0, 99);
      if (ending < 65) begin
        // proper close, sometimes also flagged as end of text
        add_word(qsu_pkg::CH_QUOTE, 1'b0, ($urandom_range(0, 4) == 0));
      end else if (ending < 80) begin
        add_fault();
        if ($urandom_range(0, 1)) push_txt(rand_plain());  // ignored after the error
      end else if (ending < 93 && text_q.size() > 1) begin
        // text runs out somewhere inside the string
        cut = $urandom_range(1, text_q.size() - 1);
        while (text_q.size() > cut + 1) void'(text_q.pop_back());
        w = text_q.pop_back();
        add_word(w.txt, w.first, 1'b1);
      end
      // otherwise left open: the next opening word restarts the decoder
    end
    send_text();
    // stray words between strings (ignored only if the decoder is idle)
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_word(8'($urandom()), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    text_byte_i    = 8'h00;
    begin_string_i = 1'b0;
    end_of_text_i  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: opening word that is also the end of text (non-quote value)
    add_word(8'h00, 1'b1, 1'b1);
    send_text();
    // a stray word after that must be ignored
    send_word(8'hff, 1'b0, 1'b0);
    // lowest/highest plain bytes, a one-byte escape, a surrogate pair, close
    add_word(qsu_pkg::CH_QUOTE, 1'b1, 1'b0);
    push_txt(qsu_pkg::CH_SPACE);
    push_txt(8'hff);
    push_txt(qsu_pkg::CH_BSL);
    push_txt("n");
    push_u(16'hd83d);
    push_u(16'hde00);
    push_txt(qsu_pkg::CH_QUOTE);
    send_text();
    // highest control byte
    add_word(qsu_pkg::CH_QUOTE, 1'b1, 1'b0);
    push_txt(8'h1f);
    send_text();
    wait_drained();

    // Random phases: none / sender idles / receiver stalls / both lightly.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 73; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 73; end
        default: begin send_idle_pct = 13; stall_pct <= 13; end
      endcase
      // full-rate sender against a long receiver hold-off backs up the block
      if (ph == 0) hold_tog <= ~hold_tog;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_string();
      wait_drained();
    end

    $display("Decoded %0d strings: %0d text words in, %0d words out, over four idle/stall phases",
             strings_sent, sb.words_in, sb.words_out);
    $display("Status codes returned (bit n set for code n): %b", sb.seen_status[10:0]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
